@@ hw/rtl/aac_pkg.sv @@
// Shared types and constants for the annealing acceptance and cooling block.
`timescale 1ns / 1ps
`default_nettype none

package aac_pkg;

    localparam int FIT_W   = 48;
    localparam int PROB_W  = 16;
    localparam int TEMP_W  = 48;
    localparam int STALL_W = 32;
    localparam int K1_W    = 16;
    localparam int K2_W    = 32;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DEN_W   = 64;
    localparam int NUM_W   = 80;
    localparam int QUO_W   = 48;
    localparam int STEP_W  = 7;
    localparam int CNT_W   = 5;
    localparam int TERM_W  = 4;
    localparam int REM_W   = MUL_W + TERM_W;
    localparam int SUM_W   = 34;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 184;

    // Quotient cap 32.0 in Q.16 for the acceptance divide
    localparam logic [QUO_W-1:0]  X_CAP     = QUO_W'(64'h0000_0000_0020_0000);
    localparam logic [MUL_W-1:0]  ONE_Q32   = MUL_W'(64'h0000_0001_0000_0000);
    // exp(-1) in Q.32, same truncated Taylor sum as the fraction path
    localparam logic [MUL_W-1:0]  EXP_M1    = MUL_W'(64'd1580030169);
    localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(13);
    localparam logic [STEP_W-1:0] STEPS_WIDE = STEP_W'(80);
    localparam logic [SUM_W-1:0]  HALF_LSB  = SUM_W'(64'h0000_0000_0000_8000);
    localparam logic [DEN_W-1:0]  ONE_DEN   = DEN_W'(64'h0000_0001_0000_0000);

    localparam logic              COOL_GEOMETRIC = 1'b1;

    localparam logic              RST_COOL_MODE = 1'b1;
    localparam logic [K1_W-1:0]   RST_K1        = K1_W'(62259);
    localparam logic [K2_W-1:0]   RST_K2        = K2_W'(4295);
    localparam logic [TEMP_W-1:0] RST_TEMP      = TEMP_W'(65536000);
    localparam logic [FIT_W-1:0]  RST_FIT       = '0;

    typedef enum logic [2:0] {
        REG_COOLING_MODE      = 3'd0,
        REG_GEOMETRIC_FACTOR  = 3'd1,
        REG_LUNDY_FACTOR      = 3'd2,
        REG_INIT_TEMPERATURE  = 3'd3,
        REG_INIT_FITNESS      = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XDIV,
        ST_TMUL,
        ST_TDIV_GO,
        ST_TDIV,
        ST_TFIX,
        ST_PLOOP,
        ST_PACC,
        ST_DECIDE,
        ST_UPDATE,
        ST_CMUL_H,
        ST_CMUL_L,
        ST_CSUM,
        ST_LDIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic              clamp;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/aac_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, optional quotient cap.
`timescale 1ns / 1ps
`default_nettype none

module aac_div (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  aac_pkg::div_ctl_t              ctl,
    input  wire  [aac_pkg::NUM_W-1:0]      dividend,
    input  wire  [aac_pkg::DEN_W-1:0]      divisor,
    output logic                           done,
    output logic [aac_pkg::QUO_W-1:0]      quotient
);

    logic [aac_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [aac_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [aac_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [aac_pkg::QUO_W-1:0]  quo_reg, quo_next;
    logic [aac_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       clamp_reg, clamp_next;
    logic                       done_reg, done_next;

    logic [aac_pkg::DEN_W:0]    shifted;
    logic [aac_pkg::DEN_W:0]    diff;
    logic                       fits;
    logic [aac_pkg::QUO_W:0]    quo_shift;

    always_comb begin
        shifted   = {rem_reg, num_reg[aac_pkg::NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        fits      = (shifted >= {1'b0, den_reg});
        quo_shift = {quo_reg, fits};

        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        clamp_next = clamp_reg;
        done_next  = 1'b0;

        if (ctl.start) begin
            num_next   = dividend;
            den_next   = divisor;
            rem_next   = '0;
            quo_next   = '0;
            cnt_next   = ctl.steps;
            clamp_next = ctl.clamp;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            rem_next = fits ? diff[aac_pkg::DEN_W-1:0] : shifted[aac_pkg::DEN_W-1:0];
            if (clamp_reg && (quo_shift > {1'b0, aac_pkg::X_CAP})) begin
                quo_next = aac_pkg::X_CAP;
            end else begin
                quo_next = quo_shift[aac_pkg::QUO_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == aac_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        clamp_reg <= clamp_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ hw/rtl/annealing_acceptance_cooling.sv @@
// Top level: Metropolis acceptance and temperature cooling sequencer with APB registers.
// Sequence: a candidate that is not worse, or any candidate at T zero, goes straight to the
//   update and cooling states; a worse candidate first runs a d/T divide, then 13 Taylor terms
//   (one multiply, a reciprocal multiply by 1/k and up to two correction steps each), one
//   multiply by exp(-1) per whole unit of d/T (up to 31) and a decide step; Lundy-Mees cooling
//   adds a divide after the cooling multiplies.
// Throughput: one item at a time; s_tready is high only in the idle state.
// Reset (synchronous, aresetn low): registers take their defaults, T = 1000.0, fitness 0.
`timescale 1ns / 1ps
`default_nettype none

module annealing_acceptance_cooling (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // candidate_fitness [47:0], random_value [63:48]
    input  wire  [aac_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // accepted [0], new_best [1], temperature_out [49:2], current_fitness_out [97:50],
    // best_fitness_out [145:98], stall_count_out [177:146], zero fill above
    output logic [aac_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [aac_pkg::ADDR_W-1:0]          paddr,
    input  wire  [aac_pkg::DATA_W-1:0]          pwdata,
    output logic [aac_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    aac_pkg::state_t state_reg, state_next;

    // Configuration registers
    logic                        mode_reg, mode_next;
    logic [aac_pkg::K1_W-1:0]    k1_reg, k1_next;
    logic [aac_pkg::K2_W-1:0]    k2_reg, k2_next;
    logic [aac_pkg::TEMP_W-1:0]  t0_reg, t0_next;
    logic [aac_pkg::FIT_W-1:0]   f0_reg, f0_next;

    // Annealing state
    logic [aac_pkg::TEMP_W-1:0]  temp_reg, temp_next;
    logic [aac_pkg::FIT_W-1:0]   cur_reg, cur_next;
    logic [aac_pkg::FIT_W-1:0]   best_reg, best_next;
    logic [aac_pkg::STALL_W-1:0] stall_reg, stall_next;

    // Per-item working registers
    logic [aac_pkg::FIT_W-1:0]   cand_reg, cand_next;
    logic [aac_pkg::PROB_W-1:0]  rnd_reg, rnd_next;
    logic [aac_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [aac_pkg::PROB_W-1:0]  y_reg, y_next;
    logic [aac_pkg::MUL_W-1:0]   t_reg, t_next;
    logic [aac_pkg::SUM_W-1:0]   pos_reg, pos_next;
    logic [aac_pkg::SUM_W-1:0]   neg_reg, neg_next;
    logic [aac_pkg::TERM_W-1:0]  k_reg, k_next;
    logic [aac_pkg::MUL_W-1:0]   p_reg, p_next;
    logic [aac_pkg::DEN_W-1:0]   part_reg, part_next;
    logic [aac_pkg::MUL_W-1:0]   tn_reg, tn_next;
    logic [aac_pkg::MUL_W-1:0]   tq_reg, tq_next;
    logic                        acc_reg, acc_next;
    logic                        nb_reg, nb_next;

    // Shared multiplier with registered product
    logic [aac_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic [aac_pkg::PROD_W-1:0]  prod_reg;

    // Shared divider
    aac_pkg::div_ctl_t           div_ctl;
    logic [aac_pkg::NUM_W-1:0]   div_num;
    logic [aac_pkg::DEN_W-1:0]   div_den;
    logic                        div_done;
    logic [aac_pkg::QUO_W-1:0]   div_quo;

    logic                        in_xfer;
    logic                        out_xfer;
    logic                        cfg_we;
    logic [2:0]                  cfg_idx;
    logic                        term_last;
    logic [aac_pkg::SUM_W-1:0]   pos_upd, neg_upd;
    logic [aac_pkg::DEN_W-1:0]   cool_sum;
    logic [aac_pkg::SUM_W-1:0]   p_round;
    logic [aac_pkg::MUL_W-1:0]   cool_factor;
    logic [aac_pkg::MUL_W-1:0]   recip;
    logic [aac_pkg::REM_W-1:0]   tq_k;
    logic [aac_pkg::REM_W-1:0]   t_rem;
    logic                        term_fix;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[aac_pkg::ADDR_W-1:3];
    assign pready   = 1'b1;

    assign s_tready = (state_reg == aac_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == aac_pkg::ST_OUT);

    assign term_last   = (k_reg == aac_pkg::LAST_TERM);
    assign pos_upd     = k_reg[0] ? pos_reg : pos_reg + aac_pkg::SUM_W'(tq_reg);
    assign neg_upd     = k_reg[0] ? neg_reg + aac_pkg::SUM_W'(tq_reg) : neg_reg;
    assign cool_sum    = part_reg + aac_pkg::DEN_W'(prod_reg[aac_pkg::PROD_W-1:16]);
    assign p_round     = aac_pkg::SUM_W'(p_reg) + aac_pkg::HALF_LSB;
    assign cool_factor = (mode_reg == aac_pkg::COOL_GEOMETRIC) ?
                         aac_pkg::MUL_W'(k1_reg) : aac_pkg::MUL_W'(k2_reg);

    // Term quotient estimate from floor(2^32 / k) falls short by at most two; step it up
    assign tq_k     = aac_pkg::REM_W'(tq_reg) * aac_pkg::REM_W'(k_reg);
    assign t_rem    = aac_pkg::REM_W'(tn_reg) - tq_k;
    assign term_fix = (t_rem >= aac_pkg::REM_W'(k_reg));

    always_comb begin
        unique case (k_reg)
            4'd1:    recip = 33'd4294967296;
            4'd2:    recip = 33'd2147483648;
            4'd3:    recip = 33'd1431655765;
            4'd4:    recip = 33'd1073741824;
            4'd5:    recip = 33'd858993459;
            4'd6:    recip = 33'd715827882;
            4'd7:    recip = 33'd613566756;
            4'd8:    recip = 33'd536870912;
            4'd9:    recip = 33'd477218588;
            4'd10:   recip = 33'd429496729;
            4'd11:   recip = 33'd390451572;
            4'd12:   recip = 33'd357913941;
            4'd13:   recip = 33'd330382099;
            default: recip = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= aac_pkg::PROD_W'(mul_a) * aac_pkg::PROD_W'(mul_b);
    end

    aac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            aac_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if ((s_tdata[47:0] >= cur_reg) || (temp_reg == '0)) begin
                        state_next = aac_pkg::ST_UPDATE;
                    end else begin
                        state_next = aac_pkg::ST_XDIV;
                    end
                end
            end
            aac_pkg::ST_XDIV: begin
                if (div_done) begin
                    state_next = (div_quo >= aac_pkg::X_CAP) ? aac_pkg::ST_UPDATE
                                                             : aac_pkg::ST_TMUL;
                end
            end
            aac_pkg::ST_TMUL:    state_next = aac_pkg::ST_TDIV_GO;
            aac_pkg::ST_TDIV_GO: state_next = aac_pkg::ST_TDIV;
            aac_pkg::ST_TDIV:    state_next = aac_pkg::ST_TFIX;
            aac_pkg::ST_TFIX: begin
                if (!term_fix) begin
                    state_next = term_last ? aac_pkg::ST_PLOOP : aac_pkg::ST_TMUL;
                end
            end
            aac_pkg::ST_PLOOP: begin
                state_next = (cnt_reg == '0) ? aac_pkg::ST_DECIDE : aac_pkg::ST_PACC;
            end
            aac_pkg::ST_PACC:   state_next = aac_pkg::ST_PLOOP;
            aac_pkg::ST_DECIDE: state_next = aac_pkg::ST_UPDATE;
            aac_pkg::ST_UPDATE: state_next = aac_pkg::ST_CMUL_H;
            aac_pkg::ST_CMUL_H: state_next = aac_pkg::ST_CMUL_L;
            aac_pkg::ST_CMUL_L: state_next = aac_pkg::ST_CSUM;
            aac_pkg::ST_CSUM: begin
                state_next = (mode_reg == aac_pkg::COOL_GEOMETRIC) ? aac_pkg::ST_OUT
                                                                   : aac_pkg::ST_LDIV;
            end
            aac_pkg::ST_LDIV: begin
                if (div_done) begin
                    state_next = aac_pkg::ST_OUT;
                end
            end
            aac_pkg::ST_OUT: begin
                if (out_xfer) begin
                    state_next = aac_pkg::ST_IDLE;
                end
            end
            default: state_next = aac_pkg::ST_IDLE;
        endcase
    end

    // Datapath and unit control
    always_comb begin
        mode_next  = mode_reg;
        k1_next    = k1_reg;
        k2_next    = k2_reg;
        t0_next    = t0_reg;
        f0_next    = f0_reg;
        temp_next  = temp_reg;
        cur_next   = cur_reg;
        best_next  = best_reg;
        stall_next = stall_reg;
        cand_next  = cand_reg;
        rnd_next   = rnd_reg;
        cnt_next   = cnt_reg;
        y_next     = y_reg;
        t_next     = t_reg;
        pos_next   = pos_reg;
        neg_next   = neg_reg;
        k_next     = k_reg;
        p_next     = p_reg;
        part_next  = part_reg;
        tn_next    = tn_reg;
        tq_next    = tq_reg;
        acc_next   = acc_reg;
        nb_next    = nb_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_ctl    = '0;
        div_num    = '0;
        div_den    = '0;

        unique case (state_reg)
            aac_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    cand_next = s_tdata[47:0];
                    rnd_next  = s_tdata[63:48];
                    nb_next   = 1'b0;
                    acc_next  = (s_tdata[47:0] >= cur_reg);
                    // Worse candidate at nonzero T: start d/T in Q.16, capped at 32.0
                    div_ctl.start = (s_tdata[47:0] < cur_reg) && (temp_reg != '0);
                    div_ctl.clamp = 1'b1;
                    div_ctl.steps = aac_pkg::STEPS_WIDE;
                    div_num       = {cur_reg - s_tdata[47:0], 32'h0};
                    div_den       = aac_pkg::DEN_W'(temp_reg);
                end
            end
            aac_pkg::ST_XDIV: begin
                if (div_done) begin
                    // Saturated quotient means probability zero
                    acc_next = (rnd_reg == '0);
                    cnt_next = div_quo[20:16];
                    y_next   = div_quo[15:0];
                    t_next   = aac_pkg::ONE_Q32;
                    pos_next = aac_pkg::SUM_W'(aac_pkg::ONE_Q32);
                    neg_next = '0;
                    k_next   = aac_pkg::TERM_W'(1);
                end
            end
            aac_pkg::ST_TMUL: begin
                mul_a = t_reg;
                mul_b = aac_pkg::MUL_W'(y_reg);
            end
            aac_pkg::ST_TDIV_GO: begin
                // Next Taylor term: ((t * y) >> 16) / k, estimated with 1/k in Q.32
                tn_next = prod_reg[48:16];
                mul_a   = prod_reg[48:16];
                mul_b   = recip;
            end
            aac_pkg::ST_TDIV: begin
                tq_next = prod_reg[64:32];
            end
            aac_pkg::ST_TFIX: begin
                if (term_fix) begin
                    tq_next = tq_reg + 1'b1;
                end else begin
                    t_next   = tq_reg;
                    pos_next = pos_upd;
                    neg_next = neg_upd;
                    k_next   = k_reg + 1'b1;
                    if (term_last) begin
                        p_next = (pos_upd > neg_upd) ? aac_pkg::MUL_W'(pos_upd - neg_upd) : '0;
                    end
                end
            end
            aac_pkg::ST_PLOOP: begin
                mul_a = p_reg;
                mul_b = aac_pkg::EXP_M1;
            end
            aac_pkg::ST_PACC: begin
                p_next   = prod_reg[64:32];
                cnt_next = cnt_reg - 1'b1;
            end
            aac_pkg::ST_DECIDE: begin
                acc_next = ({1'b0, rnd_reg} <= p_round[32:16]);
            end
            aac_pkg::ST_UPDATE: begin
                if (acc_reg) begin
                    cur_next = cand_reg;
                    if (cand_reg > best_reg) begin
                        best_next  = cand_reg;
                        stall_next = '0;
                        nb_next    = 1'b1;
                    end else if (stall_reg != '1) begin
                        stall_next = stall_reg + 1'b1;
                    end
                end
            end
            aac_pkg::ST_CMUL_H: begin
                mul_a = cool_factor;
                mul_b = aac_pkg::MUL_W'(temp_reg[47:16]);
            end
            aac_pkg::ST_CMUL_L: begin
                part_next = prod_reg[aac_pkg::DEN_W-1:0];
                mul_a     = cool_factor;
                mul_b     = aac_pkg::MUL_W'(temp_reg[15:0]);
            end
            aac_pkg::ST_CSUM: begin
                if (mode_reg == aac_pkg::COOL_GEOMETRIC) begin
                    temp_next = cool_sum[aac_pkg::TEMP_W-1:0];
                end else begin
                    // T / (1 + k2*T) with the denominator in Q.32
                    div_ctl.start = 1'b1;
                    div_ctl.clamp = 1'b0;
                    div_ctl.steps = aac_pkg::STEPS_WIDE;
                    div_num       = {temp_reg, 32'h0};
                    div_den       = aac_pkg::ONE_DEN + cool_sum;
                end
            end
            aac_pkg::ST_LDIV: begin
                if (div_done) begin
                    temp_next = div_quo[aac_pkg::TEMP_W-1:0];
                end
            end
            aac_pkg::ST_OUT: begin
                nb_next = nb_reg;
            end
            default: begin
                nb_next = nb_reg;
            end
        endcase

        // Register writes must arrive only while idle; the block itself does not enforce this
        if (cfg_we) begin
            unique case (cfg_idx)
                aac_pkg::REG_COOLING_MODE:     mode_next = pwdata[0];
                aac_pkg::REG_GEOMETRIC_FACTOR: k1_next   = pwdata[15:0];
                aac_pkg::REG_LUNDY_FACTOR:     k2_next   = pwdata[31:0];
                aac_pkg::REG_INIT_TEMPERATURE: begin
                    t0_next   = pwdata[47:0];
                    temp_next = pwdata[47:0];
                end
                aac_pkg::REG_INIT_FITNESS: begin
                    f0_next  = pwdata[47:0];
                    cur_next = pwdata[47:0];
                end
                default: mode_next = mode_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            aac_pkg::REG_COOLING_MODE:     prdata = aac_pkg::DATA_W'(mode_reg);
            aac_pkg::REG_GEOMETRIC_FACTOR: prdata = aac_pkg::DATA_W'(k1_reg);
            aac_pkg::REG_LUNDY_FACTOR:     prdata = aac_pkg::DATA_W'(k2_reg);
            aac_pkg::REG_INIT_TEMPERATURE: prdata = aac_pkg::DATA_W'(t0_reg);
            aac_pkg::REG_INIT_FITNESS:     prdata = aac_pkg::DATA_W'(f0_reg);
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aac_pkg::ST_IDLE;
            mode_reg  <= aac_pkg::RST_COOL_MODE;
            k1_reg    <= aac_pkg::RST_K1;
            k2_reg    <= aac_pkg::RST_K2;
            t0_reg    <= aac_pkg::RST_TEMP;
            f0_reg    <= aac_pkg::RST_FIT;
            temp_reg  <= aac_pkg::RST_TEMP;
            cur_reg   <= aac_pkg::RST_FIT;
            best_reg  <= '0;
            stall_reg <= '0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            k1_reg    <= k1_next;
            k2_reg    <= k2_next;
            t0_reg    <= t0_next;
            f0_reg    <= f0_next;
            temp_reg  <= temp_next;
            cur_reg   <= cur_next;
            best_reg  <= best_next;
            stall_reg <= stall_next;
        end
        cand_reg <= cand_next;
        rnd_reg  <= rnd_next;
        cnt_reg  <= cnt_next;
        y_reg    <= y_next;
        t_reg    <= t_next;
        pos_reg  <= pos_next;
        neg_reg  <= neg_next;
        k_reg    <= k_next;
        p_reg    <= p_next;
        part_reg <= part_next;
        tn_reg   <= tn_next;
        tq_reg   <= tq_next;
        acc_reg  <= acc_next;
        nb_reg   <= nb_next;
    end

    assign m_tdata = {6'h0, stall_reg, best_reg, cur_reg, temp_reg, nb_reg, acc_reg};

`ifndef SYNTHESIS
    a_best_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> best_reg >= $past(best_reg))
        else $error("best fitness decreased");

    a_stall_step: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> (stall_reg == $past(stall_reg)) || (stall_reg == '0) ||
                    (stall_reg == $past(stall_reg) + 1'b1))
        else $error("stall count moved by other than one or a clear");

    a_best_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(nb_reg && !acc_reg))
        else $error("new best reported on a rejected candidate");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == aac_pkg::ST_XDIV) || (state_reg == aac_pkg::ST_LDIV))
        else $error("divider finished outside a divide wait");
`endif

endmodule

`default_nettype wire
